/* rtl/ctsq_pkg.sv */
`default_nettype none

package ctsq_pkg;

  // sizes and limits
  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int MAX_MSG_BYTES   = 2048;
  localparam int LEN_W           = 12;

  // item codes
  typedef enum logic [2:0] {
    FUNC_HEADER   = 3'd0,
    FUNC_DATA     = 3'd1,
    FUNC_TX_DONE  = 3'd2,
    FUNC_ARB_LOST = 3'd3,
    FUNC_BUS_ERR  = 3'd4
  } func_t;

  // result codes
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_t;

  // control states
  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_RESULT = 1'b1
  } state_t;

  // input word
  typedef struct packed {
    logic [2:0]       func;
    logic [28:0]      msg_id;
    logic             extended;
    logic             remote;
    logic [LEN_W-1:0] msg_len;
    logic [7:0]       data_byte;
  } item_t;

  // output word
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  frame_status;
    logic [31:0] frame_id_word;
    logic [63:0] frame_data;
  } result_t;

  // one queued frame
  typedef struct packed {
    logic [7:0]  status;
    logic [31:0] id_word;
    logic [63:0] payload;
  } frame_t;

endpackage

`default_nettype wire

/* rtl/ctsq_frame_mem.sv */
`default_nettype none

module ctsq_frame_mem #(
  parameter int QUEUE_DEPTH = ctsq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  wire ctsq_pkg::frame_t               wr_data,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output ctsq_pkg::frame_t                    rd_data
);
  import ctsq_pkg::*;

  frame_t mem [QUEUE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/can_tx_segmenter_queue.sv */
`default_nettype none

// CAN transmit segmenter with a frame queue.
// The item channel (item_valid/item_ready/item) carries one word per event:
// a message header, one data byte, transmit complete, arbitration lost or
// bus error. Data bytes are packed eight to a frame; each finished frame is
// written into a ring queue held in a synchronous frame memory.
// The result channel (res_valid/res_ready/res) carries frames handed to the
// controller, restart requests and header rejections.
// An item that causes a result is handled in the accept cycle, in which
// the queue is read and updated, and then in a result state, in which
// the registered memory data goes to the output register once it is free.
// item_ready is low in the result state, so the block takes one item per
// cycle while items cause no results; after a result the next item waits
// until that result is loaded, as the frame memory read is registered.
// A finished result waits in the output register while the next item is
// accepted; if the receiver stalls and a second result is due, the block
// holds that item's result and drops item_ready until the register frees.
// Reset (rst, synchronous) empties the queue, clears the busy flag and the
// partial message; the memory itself is not cleared.

module can_tx_segmenter_queue #(
  parameter int QUEUE_DEPTH = ctsq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire ctsq_pkg::item_t   item,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output ctsq_pkg::result_t      res
);
  import ctsq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  // control registers
  state_t            state, state_next;
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  used, used_next;
  logic              busy, busy_next;
  logic [LEN_W-1:0]  bytes_rem, bytes_next;
  logic [2:0]        bif, bif_next;
  logic [63:0]       asm_pay, asm_next;
  logic [31:0]       cur_idw, idw_next;
  logic [1:0]        cur_flags, flags_next;

  // pending result
  kind_t             pend_kind;
  logic              fwd_sel;
  frame_t            fwd_frame;
  frame_t            rd_frame;

  // item decode
  logic              acc;
  logic              push, push_ok, want_done, tx_load, load, emit, res_load;
  kind_t             emit_kind;
  frame_t            push_frame;
  logic [31:0]       hdr_idw;
  logic [CMP_W-1:0]  need, free_cnt;
  logic [CNT_W-1:0]  used_after;
  logic [3:0]        cnt4;

  assign acc     = item_valid && item_ready;
  assign hdr_idw = item.extended ? {item.msg_id, 3'b000} : {item.msg_id[10:0], 21'd0};
  assign need    = item.remote ? CMP_W'(1)
                 : ((CMP_W'(item.msg_len) + CMP_W'(7)) >> 3);
  assign free_cnt = CMP_W'(QUEUE_DEPTH) - CMP_W'(used);
  assign cnt4    = {1'b0, bif} + 4'd1;

  // event handling
  always_comb begin
    bytes_next = bytes_rem;
    bif_next   = bif;
    asm_next   = asm_pay;
    idw_next   = cur_idw;
    flags_next = cur_flags;
    push       = 1'b0;
    push_frame = '0;
    want_done  = 1'b0;
    tx_load    = 1'b0;
    emit       = 1'b0;
    emit_kind  = KIND_LOAD;
    busy_next  = busy;
    if (acc) begin
      case (item.func)
        FUNC_HEADER: begin
          bytes_next = '0;
          bif_next   = '0;
          asm_next   = '0;
          if (item.msg_len > LEN_W'(MAX_MSG_BYTES) || need > free_cnt) begin
            emit      = 1'b1;
            emit_kind = KIND_REJECT;
          end else begin
            idw_next   = hdr_idw;
            flags_next = {item.extended, item.remote};
            if (item.remote) begin
              push               = 1'b1;
              push_frame.status  = {item.extended, 1'b1, 6'd0};
              push_frame.id_word = hdr_idw;
              push_frame.payload = '0;
              want_done          = 1'b1;
            end else begin
              bytes_next = item.msg_len;
              want_done  = (item.msg_len == '0);
            end
          end
        end
        FUNC_DATA: begin
          if (bytes_rem != '0) begin
            asm_next[{~bif, 3'b000} +: 8] = item.data_byte;
            bif_next   = bif + 3'd1;
            bytes_next = bytes_rem - LEN_W'(1);
            if (bif == 3'd7 || bytes_rem == LEN_W'(1)) begin
              push               = 1'b1;
              push_frame.status  = {cur_flags, 2'b00, cnt4};
              push_frame.id_word = cur_idw;
              push_frame.payload = asm_next;
              bif_next           = '0;
              asm_next           = '0;
              want_done          = (bytes_rem == LEN_W'(1));
            end
          end
        end
        FUNC_TX_DONE: begin
          if (used != '0) begin
            tx_load = 1'b1;
          end else begin
            busy_next = 1'b0;
          end
        end
        FUNC_ARB_LOST: begin
          emit      = 1'b1;
          emit_kind = KIND_RESTART;
        end
        FUNC_BUS_ERR: begin
          busy_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
    // queue bookkeeping
    push_ok    = push && (used < CNT_W'(QUEUE_DEPTH));
    used_after = used + CNT_W'(push_ok);
    load       = tx_load || (want_done && !busy && used_after != '0);
    used_next  = used_after - CNT_W'(load);
    if (load) begin
      emit      = 1'b1;
      emit_kind = KIND_LOAD;
      busy_next = 1'b1;
    end
  end

  // frame memory
  ctsq_frame_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (wr_ptr),
    .wr_data (push_frame),
    .rd_en   (load),
    .rd_addr (rd_ptr),
    .rd_data (rd_frame)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (acc && emit) state_next = ST_RESULT;
      ST_RESULT: if (res_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    item_ready = 1'b0;
    res_load   = 1'b0;
    case (state)
      ST_IDLE:   item_ready = 1'b1;
      ST_RESULT: res_load = !res_valid || res_ready;
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      used      <= '0;
      busy      <= 1'b0;
      bytes_rem <= '0;
      bif       <= '0;
      asm_pay   <= '0;
      cur_idw   <= '0;
      cur_flags <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      used      <= used_next;
      busy      <= busy_next;
      bytes_rem <= bytes_next;
      bif       <= bif_next;
      asm_pay   <= asm_next;
      cur_idw   <= idw_next;
      cur_flags <= flags_next;
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (load) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // pending result, forwarding a frame written in the same cycle it is read
  always_ff @(posedge clk) begin
    if (acc) begin
      pend_kind <= emit_kind;
      fwd_sel   <= push_ok && load && (wr_ptr == rd_ptr);
      fwd_frame <= push_frame;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res.result_kind <= pend_kind;
      if (pend_kind == KIND_LOAD) begin
        res.frame_status  <= fwd_sel ? fwd_frame.status  : rd_frame.status;
        res.frame_id_word <= fwd_sel ? fwd_frame.id_word : rd_frame.id_word;
        res.frame_data    <= fwd_sel ? fwd_frame.payload : rd_frame.payload;
      end else begin
        res.frame_status  <= '0;
        res.frame_id_word <= '0;
        res.frame_data    <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/ctsq_checker.sv */
`default_nettype none

module ctsq_props (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire ctsq_pkg::item_t   item,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire ctsq_pkg::result_t res
);
  import ctsq_pkg::*;

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result word present after reset");

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result word changed");

  // restart and reject words carry no frame
  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind != KIND_LOAD |->
      res.frame_status == '0 && res.frame_id_word == '0 && res.frame_data == '0)
    else $error("restart or reject word with frame fields");

  // handed-out frame has a legal length code
  a_dlc: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.result_kind == KIND_LOAD |->
      res.frame_status[3:0] <= 4'd8 && res.frame_status[5:4] == 2'b00)
    else $error("bad frame status");

  // a restart request always occupies the result cycle
  a_arb_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.func == FUNC_ARB_LOST |=> !item_ready)
    else $error("item taken while restart result pending");

endmodule

bind can_tx_segmenter_queue ctsq_props u_ctsq_props (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_ready (item_ready),
  .item       (item),
  .res_valid  (res_valid),
  .res_ready  (res_ready),
  .res        (res)
);

`default_nettype wire

/* verif/ctsq_checker.sv */
// watches both channels of the segmenter, predicts every result word and compares
module ctsq_checker
  import ctsq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_ready,
  input  item_t   item,
  input  logic    res_valid,
  input  logic    res_ready,
  input  result_t res,
  output int      errors,
  output int      waiting,
  output int      n_loads,
  output int      n_restarts,
  output int      n_rejects
);

  localparam int DEPTH = QUEUE_DEPTH_DEF;

  // predicted frame queue and message assembly state
  frame_t      frame_ring [DEPTH];
  int          wr_idx;
  int          rd_idx;
  int          used;
  logic        tx_busy;
  int          bytes_left;
  logic [3:0]  fill;
  logic [63:0] partial;
  logic [31:0] cur_id_word;
  logic        cur_ext;
  logic        cur_rtr;

  // result words still owed by the block, oldest first
  result_t frames_due [$];

  function automatic logic [7:0] flag_status();
    return {cur_ext, cur_rtr, 6'd0};
  endfunction

  task automatic queue_frame(input logic [7:0] st, input logic [63:0] pl);
    if (used < DEPTH) begin
      frame_ring[wr_idx] = '{status: st, id_word: cur_id_word, payload: pl};
      wr_idx = (wr_idx + 1) % DEPTH;
      used++;
    end
  endtask

  // head of the queue goes to the controller
  task automatic hand_out_head();
    if (used != 0) begin
      frames_due.push_back('{result_kind: KIND_LOAD,
                             frame_status: frame_ring[rd_idx].status,
                             frame_id_word: frame_ring[rd_idx].id_word,
                             frame_data: frame_ring[rd_idx].payload});
      rd_idx = (rd_idx + 1) % DEPTH;
      used--;
      tx_busy = 1'b1;
    end
  endtask

  task automatic finish_message();
    if (!tx_busy) hand_out_head();
  endtask

  task automatic plain_result(input kind_t k);
    frames_due.push_back('{result_kind: k, frame_status: '0, frame_id_word: '0,
                           frame_data: '0});
  endtask

  // one accepted input word
  task automatic segment_item(input item_t w);
    int needed;
    case (w.func)
      FUNC_HEADER: begin
        bytes_left = 0;
        fill = '0;
        partial = '0;
        needed = w.remote ? 1 : (int'(w.msg_len) + 7) / 8;
        if (int'(w.msg_len) > MAX_MSG_BYTES || needed > DEPTH - used) begin
          plain_result(KIND_REJECT);
        end else begin
          cur_id_word = w.extended ? {w.msg_id, 3'b000} : {w.msg_id[10:0], 21'd0};
          cur_ext = w.extended;
          cur_rtr = w.remote;
          if (w.remote) begin
            queue_frame(flag_status(), '0);
            finish_message();
          end else begin
            bytes_left = int'(w.msg_len);
            if (bytes_left == 0) finish_message();
          end
        end
      end
      FUNC_DATA: begin
        // bytes with no message pending are dropped
        if (bytes_left != 0) begin
          partial |= 64'(w.data_byte) << (56 - 8 * int'(fill[2:0]));
          fill++;
          bytes_left--;
          if (fill == 4'd8 || bytes_left == 0) begin
            queue_frame(flag_status() | {4'd0, fill}, partial);
            fill = '0;
            partial = '0;
            if (bytes_left == 0) finish_message();
          end
        end
      end
      FUNC_TX_DONE: begin
        if (used != 0) hand_out_head();
        else tx_busy = 1'b0;
      end
      FUNC_ARB_LOST: plain_result(KIND_RESTART);
      FUNC_BUS_ERR:  tx_busy = 1'b0;
      default: ;
    endcase
  endtask

  function automatic bit field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic check_result(input result_t got);
    result_t want;
    bit      bad;
    if (frames_due.size() == 0) begin
      errors++;
      $display("%0t: result word with none due, expected nothing actual %h", $time, got);
    end else begin
      want = frames_due.pop_front();
      bad = field_differs("result_kind", 64'(want.result_kind), 64'(got.result_kind));
      bad |= field_differs("frame_status", 64'(want.frame_status), 64'(got.frame_status));
      bad |= field_differs("frame_id_word", 64'(want.frame_id_word),
                           64'(got.frame_id_word));
      bad |= field_differs("frame_data", want.frame_data, got.frame_data);
      if (bad) errors++;
    end
    case (got.result_kind)
      KIND_LOAD:    n_loads++;
      KIND_RESTART: n_restarts++;
      KIND_REJECT:  n_rejects++;
      default: ;
    endcase
  endtask

  // sample both channels at the edge where words are taken
  always @(posedge clk) begin
    if (rst) begin
      wr_idx = 0;
      rd_idx = 0;
      used = 0;
      tx_busy = 1'b0;
      bytes_left = 0;
      fill = '0;
      partial = '0;
      cur_id_word = '0;
      cur_ext = 1'b0;
      cur_rtr = 1'b0;
      frames_due.delete();
      errors = 0;
      n_loads = 0;
      n_restarts = 0;
      n_rejects = 0;
    end else begin
      if (item_valid && item_ready) segment_item(item);
      if (res_valid && res_ready) check_result(res);
    end
    waiting = frames_due.size();
  end

endmodule

/* verif/tb_can_tx_segmenter_queue.sv */
module tb_can_tx_segmenter_queue;
  import ctsq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEM_TARGET = 1400;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 16;

  logic    clk        = 1'b0;
  logic    rst        = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item       = '0;
  logic    res_valid;
  logic    res_ready  = 1'b0;
  result_t res;

  int errors;
  int waiting;
  int n_loads;
  int n_restarts;
  int n_rejects;

  int snd_idle   = 38;
  int rcv_idle   = 78;
  int words_in   = 0;
  int rand_items = 0;
  int cycles     = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  can_tx_segmenter_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ctsq_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .errors    (errors),
    .waiting   (waiting),
    .n_loads   (n_loads),
    .n_restarts(n_restarts),
    .n_rejects (n_rejects)
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results due", $time, waiting);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (!hold_done && rand_items >= 1000) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  // word with every field random except the function code
  function automatic item_t noise_word(input logic [2:0] f);
    item_t w;
    w.func      = f;
    w.msg_id    = 29'($urandom);
    w.extended  = 1'($urandom);
    w.remote    = 1'($urandom);
    w.msg_len   = 12'($urandom);
    w.data_byte = 8'($urandom);
    return w;
  endfunction

  task automatic offer(input item_t w, input bit counted);
    while ($urandom_range(0, 99) < snd_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= w;
    do @(posedge clk); while (!item_ready);
    words_in++;
    if (counted) rand_items++;
  endtask

  task automatic send_header(input logic [28:0] id, input logic ext, input logic rtr,
                             input logic [11:0] len, input bit counted);
    item_t w;
    w = noise_word(FUNC_HEADER);
    w.msg_id = id;
    w.extended = ext;
    w.remote = rtr;
    w.msg_len = len;
    offer(w, counted);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit counted);
    item_t w;
    w = noise_word(FUNC_DATA);
    w.data_byte = b;
    offer(w, counted);
  endtask

  // controller event: mostly transmit complete
  task automatic send_event();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) offer(noise_word(FUNC_TX_DONE), 1'b1);
    else if (r < 85) offer(noise_word(FUNC_ARB_LOST), 1'b1);
    else offer(noise_word(FUNC_BUS_ERR), 1'b1);
  endtask

  // header and its bytes, sometimes cut short or followed by a stray byte
  task automatic random_message();
    int          r;
    int          len;
    int          nbytes;
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    r = $urandom_range(0, 99);
    if (r < 10) id = '1;
    else if (r < 20) id = '0;
    else id = 29'($urandom);
    ext = 1'($urandom);
    rtr = ($urandom_range(0, 99) < 12);
    r = $urandom_range(0, 99);
    if (r < 5) len = $urandom_range(MAX_MSG_BYTES + 1, 4095);
    else if (r < 25) len = $urandom_range(25, 120);
    else len = $urandom_range(0, 24);
    send_header(id, ext, rtr, 12'(len), 1'b1);
    nbytes = (rtr || len > MAX_MSG_BYTES) ? 0 : len;
    if (nbytes > 0 && $urandom_range(0, 99) < 8) nbytes = $urandom_range(0, nbytes - 1);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 99) < 25) send_event();
      send_byte(8'($urandom), 1'b1);
    end
    if ($urandom_range(0, 99) < 5) offer(noise_word(FUNC_DATA), 1'b0);
  endtask

  initial begin : stimulus
    int r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue, ignored codes, stray byte
    offer(noise_word(FUNC_TX_DONE), 1'b0);
    for (int k = 1; k <= 3; k++) offer(noise_word(FUNC_BUS_ERR + 3'(k)), 1'b0);
    offer(noise_word(FUNC_DATA), 1'b0);
    // zero-length standard message, then a remote extended one at the id extreme
    send_header('1, 1'b0, 1'b0, 12'd0, 1'b0);
    send_header('1, 1'b1, 1'b1, 12'(MAX_MSG_BYTES), 1'b0);
    // short frame queued behind the busy transmitter
    send_header('0, 1'b1, 1'b0, 12'd3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'ha5, 1'b0);
    offer(noise_word(FUNC_TX_DONE), 1'b0);
    offer(noise_word(FUNC_TX_DONE), 1'b0);
    // too long
    send_header(29'($urandom), 1'b0, 1'b0, 12'(MAX_MSG_BYTES + 1), 1'b0);
    send_header(29'($urandom), 1'b1, 1'b0, '1, 1'b0);
    // partial message dropped by a new header
    send_header(29'($urandom), 1'b1, 1'b0, 12'd10, 1'b0);
    repeat (4) send_byte(8'($urandom), 1'b0);
    send_header(29'($urandom), 1'b0, 1'b0, 12'd1, 1'b0);
    send_byte(8'($urandom), 1'b0);
    // one frame waiting, so a full-length header does not fit
    send_header(29'($urandom), 1'b0, 1'b1, 12'd5, 1'b0);
    send_header(29'($urandom), 1'b1, 1'b0, 12'(MAX_MSG_BYTES), 1'b0);
    offer(noise_word(FUNC_ARB_LOST), 1'b0);
    offer(noise_word(FUNC_BUS_ERR), 1'b0);
    offer(noise_word(FUNC_TX_DONE), 1'b0);

    // random traffic in three idle phases
    while (rand_items < ITEM_TARGET) begin
      if (rand_items < ITEM_TARGET / 3) begin
        snd_idle = 38;
        rcv_idle = 78;
      end else if (rand_items < 2 * ITEM_TARGET / 3) begin
        snd_idle = 78;
        rcv_idle = 38;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) random_message();
      else if (r < 88) repeat ($urandom_range(1, 4)) offer(noise_word(FUNC_TX_DONE), 1'b1);
      else if (r < 93) offer(noise_word(FUNC_ARB_LOST), 1'b1);
      else if (r < 97) offer(noise_word(FUNC_BUS_ERR), 1'b1);
      else offer(noise_word(FUNC_BUS_ERR + 3'($urandom_range(1, 3))), 1'b0);
    end
    item_valid <= 1'b0;

    // let the last results drain
    while (waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d input words: %0d frames handed out, %0d restarts, %0d rejections",
             words_in, n_loads, n_restarts, n_rejects);
    $display("including directed corner cases and a %0d-cycle stall that blocked the input",
             HOLD_CYCLES);
    if (errors == 0 && waiting == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* can_tx_segmenter_queue.f */
rtl/ctsq_pkg.sv
rtl/ctsq_frame_mem.sv
rtl/can_tx_segmenter_queue.sv
rtl/ctsq_checker.sv
verif/ctsq_checker.sv
verif/tb_can_tx_segmenter_queue.sv
